[src/adms_pkg.sv]
// ----------------------------------------------------------------------------
// adms_pkg
// Shared types and constants for the array degree / shortest span block.
// ----------------------------------------------------------------------------
package adms_pkg;

  localparam int unsigned NumValuesDefault = 4096;
  localparam int unsigned MaxLenDefault    = 65536;
  localparam int unsigned ValueW           = 12;
  localparam int unsigned FieldW           = 17;
  // generation tag kept with each table entry; tag 0 marks a cleared entry
  localparam int unsigned EpochW           = 8;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ctl_state_e;

  typedef struct packed {
    logic [FieldW-1:0] shortest_span;
    logic [FieldW-1:0] degree;
    logic              overflow;
  } result_t;

  typedef struct packed {
    logic last_pending;  // stage 1 holds the last element of an array
    logic wrap;          // tag space exhausted, table needs a sweep
  } core_status_t;

endpackage

[src/adms_mem.sv]
// ----------------------------------------------------------------------------
// adms_mem
// Single-port-write, single-port-read table with registered read data.
// ----------------------------------------------------------------------------
module adms_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/adms_core.sv]
// ----------------------------------------------------------------------------
// adms_core
// Update stage: merges table read data with the last write, bumps the count,
// forms the span, tracks degree and shortest span, and closes each array.
// ----------------------------------------------------------------------------
module adms_core import adms_pkg::*; #(
  parameter int unsigned NUM_VALUES = NumValuesDefault,
  parameter int unsigned MAX_LEN    = MaxLenDefault,
  parameter int unsigned DEPTH      = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [ValueW-1:0]        value_i,
  input  logic                     is_last_i,
  input  logic [EpochW+$clog2(MAX_LEN+1)+$clog2(MAX_LEN)-1:0] rdata_i,
  output logic                     we_o,
  output logic [$clog2(DEPTH)-1:0] waddr_o,
  output logic [EpochW+$clog2(MAX_LEN+1)+$clog2(MAX_LEN)-1:0] wdata_o,
  output logic                     push_o,
  output result_t                  result_o,
  output core_status_t             status_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned PW   = $clog2(MAX_LEN + 1);
  localparam int unsigned FW   = $clog2(MAX_LEN);
  localparam int unsigned EntW = EpochW + PW + FW;
  localparam bit          AllInRange = NUM_VALUES >= (1 << ValueW);
  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [EpochW-1:0] EpochMax   = '1;
  localparam logic [PW-1:0]     PosLimit   = PW'(MAX_LEN);

  logic              s1_valid_q;
  logic [ValueW-1:0] s1_value_q;
  logic              s1_last_q;

  logic              fwd_valid_q;
  logic [AW-1:0]     fwd_addr_q;
  logic [EntW-1:0]   fwd_data_q;

  logic [PW-1:0]     position_q, position_d;
  logic [PW-1:0]     best_count_q, best_count_d;
  logic [PW-1:0]     best_span_q, best_span_d;
  logic              ovf_q, ovf_d;
  logic [EpochW-1:0] epoch_q, epoch_d;

  logic [AW-1:0]     s1_addr;
  logic [EntW-1:0]   entry;
  logic [EpochW-1:0] e_tag;
  logic [PW-1:0]     e_cnt;
  logic [FW-1:0]     e_first;
  logic              live, in_len, in_range, counted;
  logic [PW-1:0]     cnt_new, span;
  logic [FW-1:0]     first;
  logic [PW-1:0]     pos_n, bc_n, bs_n;
  logic              ovf_n;
  logic [PW+FieldW-1:0] span_ext, cnt_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= fire_i;
      fwd_valid_q <= counted;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      s1_value_q <= value_i;
      s1_last_q  <= is_last_i;
    end
    if (counted) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= wdata_o;
    end
  end

  always_comb begin
    s1_addr  = s1_value_q[AW-1:0];
    entry    = (fwd_valid_q && fwd_addr_q == s1_addr) ? fwd_data_q : rdata_i;
    e_tag    = entry[EntW-1 -: EpochW];
    e_cnt    = entry[PW+FW-1 -: PW];
    e_first  = entry[FW-1:0];
    live     = e_tag == epoch_q;
    in_len   = position_q != PosLimit;
    in_range = AllInRange || (32'(s1_value_q) < NUM_VALUES);
    counted  = s1_valid_q && in_len && in_range;
    cnt_new  = (live ? e_cnt : '0) + PW'(1);
    first    = live ? e_first : position_q[FW-1:0];
    span     = position_q - PW'(first) + PW'(1);
  end

  always_comb begin
    pos_n = position_q;
    bc_n  = best_count_q;
    bs_n  = best_span_q;
    ovf_n = ovf_q;
    if (s1_valid_q) begin
      if (in_len) begin
        pos_n = position_q + PW'(1);
      end else begin
        ovf_n = 1'b1;
      end
    end
    if (counted) begin
      priority if (cnt_new > best_count_q) begin
        bc_n = cnt_new;
        bs_n = span;
      end else if (cnt_new == best_count_q && span < best_span_q) begin
        bs_n = span;
      end
    end
  end

  always_comb begin
    push_o   = s1_valid_q && s1_last_q;
    span_ext = {{FieldW{1'b0}}, bs_n};
    cnt_ext  = {{FieldW{1'b0}}, bc_n};
    result_o.shortest_span = span_ext[FieldW-1:0];
    result_o.degree        = cnt_ext[FieldW-1:0];
    result_o.overflow      = ovf_n;

    position_d   = pos_n;
    best_count_d = bc_n;
    best_span_d  = bs_n;
    ovf_d        = ovf_n;
    epoch_d      = epoch_q;
    status_o.wrap = 1'b0;
    if (push_o) begin
      position_d   = '0;
      best_count_d = '0;
      best_span_d  = '0;
      ovf_d        = 1'b0;
      if (epoch_q == EpochMax) begin
        epoch_d       = EpochFirst;
        status_o.wrap = 1'b1;
      end else begin
        epoch_d = epoch_q + EpochW'(1);
      end
    end
    status_o.last_pending = push_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q   <= '0;
      best_count_q <= '0;
      best_span_q  <= '0;
      ovf_q        <= 1'b0;
      epoch_q      <= EpochFirst;
    end else begin
      position_q   <= position_d;
      best_count_q <= best_count_d;
      best_span_q  <= best_span_d;
      ovf_q        <= ovf_d;
      epoch_q      <= epoch_d;
    end
  end

  assign we_o    = counted;
  assign waddr_o = s1_addr;
  assign wdata_o = {epoch_q, cnt_new, first};

endmodule

[src/adms_out_buf.sv]
// ----------------------------------------------------------------------------
// adms_out_buf
// Two-entry result queue between the update stage and the output channel.
// ----------------------------------------------------------------------------
module adms_out_buf import adms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  result_t    data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    data_o,
  output logic [1:0] count_o
);

  result_t    buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign data_o      = buf_q[rd_q];
  assign count_o     = cnt_q;

endmodule

[src/array_degree_min_span.sv]
// ----------------------------------------------------------------------------
// array_degree_min_span
// Degree of an array and the shortest contiguous span that reaches it.
// ----------------------------------------------------------------------------
// Takes one element per cycle while in_ready_o is high; the table
// read-modify-write is split into a registered read, then update and
// write-back, with the previous write forwarded when the same value repeats,
// so back-to-back elements run at full rate. The result for an array is
// pushed into a two-entry queue when its last element is in the update stage,
// and waits there; the input stalls while that queue cannot take another
// result. Each table entry carries a generation tag, so closing an array needs
// no table clear; after reset, and again after every 255 arrays, a sweep over
// all min(NUM_VALUES, 4096) entries clears the table and the input is held off until it finishes.
module array_degree_min_span import adms_pkg::*; #(
  parameter int unsigned NUM_VALUES = NumValuesDefault,
  parameter int unsigned MAX_LEN    = MaxLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  input  logic              is_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FieldW-1:0] shortest_span_o,
  output logic [FieldW-1:0] degree_o,
  output logic              overflow_o
);

  localparam int unsigned DEPTH = (NUM_VALUES < (1 << ValueW)) ? NUM_VALUES : (1 << ValueW);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EntW  = EpochW + $clog2(MAX_LEN + 1) + $clog2(MAX_LEN);

  ctl_state_e   state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clearing;

  logic          fire;
  logic          core_we, mem_we;
  logic [AW-1:0] core_waddr, mem_waddr;
  logic [EntW-1:0] core_wdata, mem_wdata, rdata;
  logic          push;
  result_t       result, out_data;
  core_status_t  status;
  logic [1:0]    q_count;
  logic [2:0]    occ;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.wrap) begin
          state_d = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = state_q == ST_CLEAR;
    clr_cnt_d = clearing ? clr_cnt_q + AW'(1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // queue room once the pending last element and this request land
  assign occ = 3'(q_count) + 3'(status.last_pending) - 3'(out_valid_o && out_ready_i);
  assign in_ready_o = (state_q == ST_RUN) && !status.wrap && (occ <= 3'd1);
  assign fire       = in_valid_i && in_ready_o;

  assign mem_we    = clearing || core_we;
  assign mem_waddr = clearing ? clr_cnt_q : core_waddr;
  assign mem_wdata = clearing ? '0 : core_wdata;

  adms_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EntW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (fire),
    .raddr_i (value_i[AW-1:0]),
    .rdata_o (rdata)
  );

  adms_core #(
    .NUM_VALUES (NUM_VALUES),
    .MAX_LEN    (MAX_LEN),
    .DEPTH      (DEPTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .value_i   (value_i),
    .is_last_i (is_last_i),
    .rdata_i   (rdata),
    .we_o      (core_we),
    .waddr_o   (core_waddr),
    .wdata_o   (core_wdata),
    .push_o    (push),
    .result_o  (result),
    .status_o  (status)
  );

  adms_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_data),
    .count_o     (q_count)
  );

  assign shortest_span_o = out_data.shortest_span;
  assign degree_o        = out_data.degree;
  assign overflow_o      = out_data.overflow;

endmodule

[src/adms_checker.sv]
// ----------------------------------------------------------------------------
// adms_checker
// Port-level checks for array_degree_min_span, bound to the top level.
// ----------------------------------------------------------------------------
module adms_checker import adms_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [ValueW-1:0] value_i,
  input logic              is_last_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [FieldW-1:0] shortest_span_o,
  input logic [FieldW-1:0] degree_o,
  input logic              overflow_o
);

  // table sweep follows reset, no request taken right away
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("request taken during table sweep");

  // an empty array reports zero span
  a_zero_degree_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degree_o == '0 |-> shortest_span_o == '0)
    else $error("zero degree with nonzero span");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(degree_o)
      && $stable(shortest_span_o) && $stable(overflow_o))
    else $error("result dropped or changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i) && $stable(is_last_i))
    else $error("request dropped or changed while stalled");

endmodule

bind array_degree_min_span adms_checker u_adms_checker (.*);
